[hw/rtl/fifo_queue_with_membership_search_top_macros.svh]
// Assertion helpers used by the checker file.
`ifndef FIFO_QUEUE_WITH_MEMBERSHIP_SEARCH_TOP_MACROS_SVH
`define FIFO_QUEUE_WITH_MEMBERSHIP_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, held off during reset.
`define FQMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define FQMS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/fqms_pkg.sv]
package fqms_pkg;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Default ring size
  localparam int DEFAULT_DEPTH = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

[hw/rtl/fifo_queue_with_membership_search_top.sv]
// Enqueue and unused codes load the result directly; dequeue does so when the queue is or ends empty,
// else it first reads the new head from the ring memory; a search of a nonempty queue reads each stored entry.
// Throughput: one request at a time, so the length of a search is bounded
// by the single read port of the ring memory (one stored entry compared per cycle).
// Reset: synchronous, active low; clears head, tail, count and handshake state. The ring
// memory is not cleared and needs no clearing pass.
module fifo_queue_with_membership_search_top #(
  parameter int QUEUE_DEPTH = fqms_pkg::DEFAULT_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [fqms_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [fqms_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fqms_pkg::STATUS_W-1:0]       out_status,
  output logic signed [fqms_pkg::VALUE_W-1:0] out_popped_value,
  output logic                                out_found,
  output logic signed [fqms_pkg::VALUE_W-1:0] out_front_value,
  output logic                                out_is_empty,
  output logic [fqms_pkg::COUNT_W-1:0]        out_count
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int EXT_W = CNT_W + fqms_pkg::COUNT_W;
  localparam int VW    = fqms_pkg::VALUE_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_DEQ_RD, S_SCAN} state_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  // Ring memory, one write and one registered read port
  logic [VW-1:0]    mem [QUEUE_DEPTH];
  logic [VW-1:0]    rd_data_r;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] rd_addr;

  // Control and queue state
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [VW-1:0]    front_r, front_nxt;
  logic [VW-1:0]    key_r, key_nxt;
  logic             hit_r, hit_nxt, hit_now;
  logic             rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;

  // Result register
  logic                         out_valid_r, out_valid_nxt;
  logic [fqms_pkg::STATUS_W-1:0] out_status_r;
  logic [VW-1:0]                out_popped_r;
  logic                         out_found_r;
  logic [VW-1:0]                out_front_r;
  logic                         out_empty_r;
  logic [fqms_pkg::COUNT_W-1:0] out_count_r;

  // Result load controls
  logic                          load;
  logic [fqms_pkg::STATUS_W-1:0] ld_status;
  logic [VW-1:0]                 ld_popped;
  logic                          ld_found;
  logic [EXT_W-1:0]              cnt_ext;
  logic                          slot_free, in_take;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !slot_free;
  assign in_take   = in_valid && !in_stall;
  assign cnt_ext   = EXT_W'(count_nxt);

  // Next-state logic
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    front_nxt    = front_r;
    key_nxt      = key_r;
    hit_nxt      = hit_r;
    rd_vld_nxt   = rd_vld_r;
    left_nxt     = left_r;
    scan_idx_nxt = scan_idx_r;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = scan_idx_r;
    load         = 1'b0;
    ld_status    = fqms_pkg::ST_OK;
    ld_popped    = '0;
    ld_found     = 1'b0;
    hit_now      = hit_r | (rd_vld_r && (rd_data_r == key_r));

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          key_nxt = in_value;
          unique case (in_cmd)
            fqms_pkg::CMD_ENQ: begin
              load = 1'b1;
              if (count_r == FULL_CNT) begin
                ld_status = fqms_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                tail_nxt  = idx_inc(tail_r);
                count_nxt = count_r + 1'b1;
                // write-through when the new word becomes the front
                if (count_r == '0) begin
                  front_nxt = in_value;
                end
              end
            end
            fqms_pkg::CMD_DEQ: begin
              if (count_r == '0) begin
                load      = 1'b1;
                ld_status = fqms_pkg::ST_EMPTY;
              end else begin
                head_nxt  = idx_inc(head_r);
                count_nxt = count_r - 1'b1;
                if (count_r == CNT_W'(1)) begin
                  load      = 1'b1;
                  ld_popped = front_r;
                end else begin
                  // fetch the new front
                  rd_en     = 1'b1;
                  rd_addr   = idx_inc(head_r);
                  state_nxt = S_DEQ_RD;
                end
              end
            end
            fqms_pkg::CMD_FIND: begin
              if (count_r == '0) begin
                load = 1'b1;
              end else begin
                rd_en        = 1'b1;
                rd_addr      = head_r;
                scan_idx_nxt = idx_inc(head_r);
                left_nxt     = count_r - 1'b1;
                rd_vld_nxt   = 1'b1;
                hit_nxt      = 1'b0;
                state_nxt    = S_SCAN;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_DEQ_RD: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_popped = front_r;
          front_nxt = rd_data_r;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        hit_nxt = hit_now;
        if (left_r != '0) begin
          // issue next read, compare the previous one
          rd_en        = 1'b1;
          rd_addr      = scan_idx_r;
          scan_idx_nxt = idx_inc(scan_idx_r);
          left_nxt     = left_r - 1'b1;
          rd_vld_nxt   = 1'b1;
        end else begin
          rd_vld_nxt = 1'b0;
          if (slot_free) begin
            load      = 1'b1;
            ld_found  = hit_now;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = load | (out_valid_r & out_stall);
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
      front_r     <= front_nxt;
      key_r       <= key_nxt;
      hit_r       <= hit_nxt;
      scan_idx_r  <= scan_idx_nxt;
      if (load) begin
        out_status_r <= ld_status;
        out_popped_r <= ld_popped;
        out_found_r  <= ld_found;
        out_front_r  <= (count_nxt == '0) ? '0 : front_nxt;
        out_empty_r  <= (count_nxt == '0);
        out_count_r  <= cnt_ext[fqms_pkg::COUNT_W-1:0];
      end
    end
  end

  // Ring write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= in_value;
    end
  end

  // Ring read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_popped_r;
  assign out_found        = out_found_r;
  assign out_front_value  = out_front_r;
  assign out_is_empty     = out_empty_r;
  assign out_count        = out_count_r;

endmodule

[hw/rtl/fqms_checker.sv]
`include "fifo_queue_with_membership_search_top_macros.svh"

module fqms_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [fqms_pkg::CMD_W-1:0]          in_cmd,
  input logic signed [fqms_pkg::VALUE_W-1:0] in_value,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [fqms_pkg::STATUS_W-1:0]       out_status,
  input logic signed [fqms_pkg::VALUE_W-1:0] out_popped_value,
  input logic                                out_found,
  input logic signed [fqms_pkg::VALUE_W-1:0] out_front_value,
  input logic                                out_is_empty,
  input logic [fqms_pkg::COUNT_W-1:0]        out_count
);

  // An empty queue shows no count and a zero front
  `FQMS_ASSERT_IMP(a_empty_view, clk, rst_n, out_valid && out_is_empty, (out_count == '0) && (out_front_value == '0), "empty result with nonzero count or front")

  // A failed dequeue pops nothing and reports an empty queue
  `FQMS_ASSERT_IMP(a_deq_empty, clk, rst_n, out_valid && (out_status == fqms_pkg::ST_EMPTY), out_is_empty && (out_popped_value == '0), "dequeue on empty reported data")

  // A search hit needs a stored entry; a dropped enqueue pops or finds nothing
  `FQMS_ASSERT_IMP(a_found_nonempty, clk, rst_n, out_valid && out_found, !out_is_empty && (out_status == fqms_pkg::ST_OK), "found on empty queue")
  `FQMS_ASSERT_IMP(a_full_quiet, clk, rst_n, out_valid && (out_status == fqms_pkg::ST_FULL), !out_found && (out_popped_value == '0) && !out_is_empty, "full drop with side data")

  // A stalled result holds
  `FQMS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_count) && $stable(out_front_value) && $stable(out_status), "stalled result changed")

endmodule

bind fifo_queue_with_membership_search_top fqms_checker u_fqms_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_cmd           (in_cmd),
  .in_value         (in_value),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_popped_value (out_popped_value),
  .out_found        (out_found),
  .out_front_value  (out_front_value),
  .out_is_empty     (out_is_empty),
  .out_count        (out_count)
);
